[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers on clk_i with reset rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds out of reset
`define ASSERT_NEVER_CLK(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER_CLK(label, cond, msg)
`endif
`endif

[hw/rtl/lkm_pkg.sv]
// ----------------------------------------------------------------------------
// lkm_pkg
// Shared constants and memory request types of the line k-median block.
// ----------------------------------------------------------------------------
`default_nettype none
package lkm_pkg;
  localparam int MAX_HOUSES = 64;
  localparam int HADDR_W    = $clog2(MAX_HOUSES);
  localparam int CNT_W      = HADDR_W + 1;
  localparam int PRE_AW     = $clog2(MAX_HOUSES + 1);
  localparam int DP_AW      = HADDR_W + 1;
  localparam int POS_W      = 16;
  localparam int PRE_W      = POS_W + HADDR_W + 1;
  localparam int DP_W       = 22;
  localparam int K_W        = 7;

  // House and prefix memory requests
  typedef struct packed {
    logic                  hs_we;
    logic [HADDR_W-1:0]    hs_waddr;
    logic [POS_W-1:0]      hs_wdata;
    logic [HADDR_W-1:0]    hs_raddr;
    logic                  pre_we;
    logic [PRE_AW-1:0]     pre_waddr;
    logic [PRE_W-1:0]      pre_wdata;
    logic [PRE_AW-1:0]     pre_raddr_a;
    logic [PRE_AW-1:0]     pre_raddr_b;
  } store_req_t;

  // DP row memory request
  typedef struct packed {
    logic              we;
    logic [DP_AW-1:0]  waddr;
    logic [DP_W-1:0]   wdata;
    logic [DP_AW-1:0]  raddr;
  } dp_req_t;
endpackage
`default_nettype wire

[hw/rtl/line_k_median_min_distance_top.sv]
// Houses load one per cycle while the block is in its load state; after the last
// one the block sorts them by insertion sort, builds prefix sums and runs the DP,
// evaluating one run cost at a time, and then hands off the result.
// Input is stalled during computation; the result sits in an output register.
// Reset clears control state, house count and sets office_count to 1.
// ----------------------------------------------------------------------------
// line_k_median_min_distance_top
// Loads house positions, sorts them and places offices by a two-row DP.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module line_k_median_min_distance_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,      // office_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,     // house_position
  input  wire logic        s_axis_tlast,     // last_house
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata      // min_total_distance, zero pad
);
  localparam int CW   = lkm_pkg::CNT_W;
  localparam int HW   = lkm_pkg::HADDR_W;
  localparam int PW   = lkm_pkg::PRE_W;
  localparam int DW   = lkm_pkg::DP_W;
  localparam int PRW  = lkm_pkg::POS_W + CW + 1;
  localparam int SW   = PRW + 2;
  localparam int CDW  = DW + 2;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SI    = 4'd2;
  localparam logic [3:0] S_SV    = 4'd3;
  localparam logic [3:0] S_SC    = 4'd4;
  localparam logic [3:0] S_SW    = 4'd5;
  localparam logic [3:0] S_PR    = 4'd6;
  localparam logic [3:0] S_PA    = 4'd7;
  localparam logic [3:0] S_RS    = 4'd8;
  localparam logic [3:0] S_C1    = 4'd9;
  localparam logic [3:0] S_C2    = 4'd10;
  localparam logic [3:0] S_C3    = 4'd11;
  localparam logic [3:0] S_C4    = 4'd12;
  localparam logic [3:0] S_RD    = 4'd13;
  localparam logic [3:0] S_RW    = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]                  state_q, state_d;
  logic [6:0]                  office_q;
  logic [CW-1:0]               total_q, total_d;
  logic [CW-1:0]               n_q, n_d;
  logic [CW-1:0]               i_q, i_d;
  logic [CW-1:0]               j_q, j_d;
  logic [CW-1:0]               r_q, r_d;
  logic                        init_q, init_d;
  logic                        out_valid_q, out_valid_d;
  logic [DW-1:0]               out_data_q, out_data_d;
  logic [DW-1:0]               res_q, res_d;
  logic [lkm_pkg::POS_W-1:0]   v_q, v_d;
  logic signed [PW-1:0]        acc_q, acc_d;
  logic signed [lkm_pkg::POS_W-1:0] m_q, m_d;
  logic signed [PW-1:0]        plo_q, plo_d, phi_q, phi_d, pmid_q, pmid_d;
  logic [DW-1:0]               prev_q, prev_d;
  logic signed [PRW-1:0]       prodl_q, prodl_d, prodr_q, prodr_d;
  logic [CDW-1:0]              best_q, best_d;

  lkm_pkg::store_req_t         st_req;
  lkm_pkg::dp_req_t            dp_req;
  logic [lkm_pkg::POS_W-1:0]   hs_rdata;
  logic [PW-1:0]               pre_rdata_a, pre_rdata_b;
  logic [DW-1:0]               dp_rdata;

  logic [CW-1:0]               lo, mid, k_m1, n_m1;
  logic [CW:0]                 lohi;
  logic signed [SW-1:0]        cost_s;
  logic [CDW-1:0]              cand, new_best;
  logic                        in_acc;

  // Prefix memory address from a count
  function automatic logic [lkm_pkg::PRE_AW-1:0] PRE_ADDR(input logic [CW-1:0] c);
    PRE_ADDR = lkm_pkg::PRE_AW'(c);
  endfunction

  lkm_store u_store (
    .clk_i         (clk_i),
    .req_i         (st_req),
    .hs_rdata_o    (hs_rdata),
    .pre_rdata_a_o (pre_rdata_a),
    .pre_rdata_b_o (pre_rdata_b)
  );

  lkm_dp_mem u_dp (
    .clk_i   (clk_i),
    .req_i   (dp_req),
    .rdata_o (dp_rdata)
  );

  // Run bounds and median of the current cost evaluation
  assign lo     = init_q ? '0 : CW'(r_q + 1'b1);
  assign lohi   = (CW + 1)'(lo) + (CW + 1)'(j_q);
  assign mid    = lohi[CW:1];
  assign k_m1   = CW'(office_q - 1'b1);
  assign n_m1   = n_q - 1'b1;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Run cost from prefix sums and products
  assign cost_s = SW'(prodl_q) - SW'(pmid_q) + SW'(plo_q) + SW'(phi_q)
                - SW'(pmid_q) - SW'(m_q) - SW'(prodr_q);
  assign cand   = (init_q ? '0 : CDW'(prev_q)) + CDW'(cost_s[DW:0]);
  assign new_best = ((r_q == '0) || (cand < best_q)) ? cand : best_q;

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 24'(out_data_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    r_d         = r_q;
    init_d      = init_q;
    res_d       = res_q;
    v_d         = v_q;
    acc_d       = acc_q;
    m_d         = m_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    pmid_d      = pmid_q;
    prev_d      = prev_q;
    prodl_d     = prodl_q;
    prodr_d     = prodr_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    st_req      = '0;
    dp_req      = '0;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (total_q < CW'(lkm_pkg::MAX_HOUSES)) begin
            st_req.hs_we    = 1'b1;
            st_req.hs_waddr = total_q[HW-1:0];
            st_req.hs_wdata = s_axis_tdata;
            total_d         = total_q + 1'b1;
          end
          if (s_axis_tlast) begin
            n_d     = total_d;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if ((office_q == '0) || (office_q >= 7'(n_q))) begin
          res_d   = '0;
          state_d = S_DONE;
        end else begin
          i_d     = CW'(1);
          state_d = S_SI;
        end
      end
      // Insertion sort in the house memory
      S_SI: begin
        if (i_q == n_q) begin
          state_d = S_PR;
        end else begin
          st_req.hs_raddr = i_q[HW-1:0];
          state_d         = S_SV;
        end
      end
      S_SV: begin
        v_d             = hs_rdata;
        j_d             = i_q;
        st_req.hs_raddr = HW'(i_q - 1'b1);
        state_d         = S_SC;
      end
      S_SC: begin
        st_req.hs_we    = 1'b1;
        st_req.hs_waddr = j_q[HW-1:0];
        if ($signed(hs_rdata) > $signed(v_q)) begin
          st_req.hs_wdata = hs_rdata;
          j_d             = j_q - 1'b1;
          if (j_q == CW'(1)) begin
            state_d = S_SW;
          end else begin
            st_req.hs_raddr = HW'(j_q - 2'd2);
          end
        end else begin
          st_req.hs_wdata = v_q;
          i_d             = i_q + 1'b1;
          state_d         = S_SI;
        end
      end
      S_SW: begin
        st_req.hs_we    = 1'b1;
        st_req.hs_waddr = '0;
        st_req.hs_wdata = v_q;
        i_d             = i_q + 1'b1;
        state_d         = S_SI;
      end
      // Prefix sums of sorted positions
      S_PR: begin
        st_req.pre_we    = 1'b1;
        st_req.pre_waddr = '0;
        st_req.pre_wdata = '0;
        st_req.hs_raddr  = '0;
        r_d              = '0;
        acc_d            = '0;
        state_d          = S_PA;
      end
      S_PA: begin
        acc_d            = acc_q + PW'($signed(hs_rdata));
        st_req.pre_we    = 1'b1;
        st_req.pre_waddr = PRE_ADDR(r_q + 1'b1);
        st_req.pre_wdata = acc_d;
        st_req.hs_raddr  = HW'(r_q + 1'b1);
        r_d              = r_q + 1'b1;
        if (CW'(r_q + 1'b1) == n_q) begin
          init_d  = 1'b1;
          j_d     = '0;
          r_d     = '0;
          state_d = S_C1;
        end
      end
      // Start a DP row: a single house costs nothing
      S_RS: begin
        dp_req.we    = 1'b1;
        dp_req.waddr = {i_q[0], HW'(0)};
        dp_req.wdata = '0;
        j_d          = CW'(1);
        r_d          = '0;
        state_d      = S_C1;
      end
      S_C1: begin
        st_req.hs_raddr    = mid[HW-1:0];
        st_req.pre_raddr_a = PRE_ADDR(lo);
        st_req.pre_raddr_b = PRE_ADDR(j_q + 1'b1);
        dp_req.raddr       = {~i_q[0], r_q[HW-1:0]};
        state_d            = S_C2;
      end
      S_C2: begin
        m_d                = $signed(hs_rdata);
        plo_d              = $signed(pre_rdata_a);
        phi_d              = $signed(pre_rdata_b);
        prev_d             = dp_rdata;
        st_req.pre_raddr_a = PRE_ADDR(mid);
        state_d            = S_C3;
      end
      S_C3: begin
        pmid_d  = $signed(pre_rdata_a);
        prodl_d = PRW'(m_q * $signed({1'b0, CW'(mid - lo)}));
        prodr_d = PRW'(m_q * $signed({1'b0, CW'(j_q - mid)}));
        state_d = S_C4;
      end
      S_C4: begin
        if (init_q) begin
          dp_req.we    = 1'b1;
          dp_req.waddr = {1'b0, j_q[HW-1:0]};
          dp_req.wdata = cand[DW-1:0];
          j_d          = j_q + 1'b1;
          state_d      = S_C1;
          if (j_d == n_q) begin
            init_d = 1'b0;
            if (office_q == 7'd1) begin
              state_d = S_RD;
            end else begin
              i_d     = CW'(1);
              state_d = S_RS;
            end
          end
        end else begin
          best_d  = new_best;
          r_d     = r_q + 1'b1;
          state_d = S_C1;
          if (r_d == j_q) begin
            dp_req.we    = 1'b1;
            dp_req.waddr = {i_q[0], j_q[HW-1:0]};
            dp_req.wdata = new_best[DW-1:0];
            j_d          = j_q + 1'b1;
            r_d          = '0;
            if (j_d == n_q) begin
              i_d = i_q + 1'b1;
              if (7'(i_d) == office_q) begin
                state_d = S_RD;
              end else begin
                state_d = S_RS;
              end
            end
          end
        end
      end
      S_RD: begin
        dp_req.raddr = {k_m1[0], n_m1[HW-1:0]};
        state_d      = S_RW;
      end
      S_RW: begin
        res_d   = dp_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          total_d     = '0;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      office_q    <= 7'd1;
      total_q     <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        office_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    i_q        <= i_d;
    j_q        <= j_d;
    r_q        <= r_d;
    res_q      <= res_d;
    v_q        <= v_d;
    acc_q      <= acc_d;
    m_q        <= m_d;
    plo_q      <= plo_d;
    phi_q      <= phi_d;
    pmid_q     <= pmid_d;
    prev_q     <= prev_d;
    prodl_q    <= prodl_d;
    prodr_q    <= prodr_d;
    best_q     <= best_d;
    out_data_q <= out_data_d;
  end

  `ASSERT_CLK(a_total_bound, total_q <= CW'(lkm_pkg::MAX_HOUSES), "house count overflow")
  `ASSERT_NEVER_CLK(a_no_store_full_write, st_req.hs_we && (state_q == S_LOAD) && (total_q == CW'(lkm_pkg::MAX_HOUSES)), "write into full store")
  `ASSERT_CLK(a_load_stays, (state_q == S_LOAD) && !(s_axis_tvalid && s_axis_tlast) |=> state_q == S_LOAD, "left load without last house")
  `ASSERT_NEVER_CLK(a_dp_row_clash, dp_req.we && !init_q && (state_q == S_C4) && (dp_req.waddr[HW] != i_q[0]), "DP write into previous row")
endmodule
`default_nettype wire

[hw/rtl/lkm_store.sv]
// ----------------------------------------------------------------------------
// lkm_store
// House position memory and prefix sum memory, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none
module lkm_store (
  input  wire logic                      clk_i,
  input  wire lkm_pkg::store_req_t       req_i,
  output logic [lkm_pkg::POS_W-1:0]      hs_rdata_o,
  output logic [lkm_pkg::PRE_W-1:0]      pre_rdata_a_o,
  output logic [lkm_pkg::PRE_W-1:0]      pre_rdata_b_o
);
  logic [lkm_pkg::POS_W-1:0] hs_mem [lkm_pkg::MAX_HOUSES];
  logic [lkm_pkg::PRE_W-1:0] pre_mem [lkm_pkg::MAX_HOUSES + 1];

  // House memory: one write, one read
  always_ff @(posedge clk_i) begin
    if (req_i.hs_we) begin
      hs_mem[req_i.hs_waddr] <= req_i.hs_wdata;
    end
    hs_rdata_o <= hs_mem[req_i.hs_raddr];
  end

  // Prefix memory: one write, two reads
  always_ff @(posedge clk_i) begin
    if (req_i.pre_we) begin
      pre_mem[req_i.pre_waddr] <= req_i.pre_wdata;
    end
    pre_rdata_a_o <= pre_mem[req_i.pre_raddr_a];
    pre_rdata_b_o <= pre_mem[req_i.pre_raddr_b];
  end
endmodule
`default_nettype wire

[hw/rtl/lkm_dp_mem.sv]
// ----------------------------------------------------------------------------
// lkm_dp_mem
// Two DP rows in one memory; row select is the top address bit.
// ----------------------------------------------------------------------------
`default_nettype none
module lkm_dp_mem (
  input  wire logic                    clk_i,
  input  wire lkm_pkg::dp_req_t        req_i,
  output logic [lkm_pkg::DP_W-1:0]     rdata_o
);
  logic [lkm_pkg::DP_W-1:0] mem [2 * lkm_pkg::MAX_HOUSES];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end
endmodule
`default_nettype wire

[verif/line_k_median_min_distance_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_k_median_min_distance_top_tb
// Streams sets of house positions into the block and checks each least total
// distance against a sort-and-DP model, with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module line_k_median_min_distance_top_tb;

  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct packed {
    logic [lkm_pkg::POS_W-1:0] pos;
    logic                      last;
  } house_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [lkm_pkg::K_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;

  house_item_t      pending_houses[$];
  logic [lkm_pkg::DP_W-1:0] expected_dist[$];
  int               error_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               idle_cycles = 0;

  // model state
  int               office_k = 1;
  int               loaded_pos[$];

  line_k_median_min_distance_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Least total distance of the set with k offices at run medians
  function automatic logic [lkm_pkg::DP_W-1:0] least_distance(input int pts[$], input int k);
    int      n;
    int      v;
    int      j;
    int      mid;
    longint  pre[65];
    longint  cost[64][64];
    longint  prev_row[64];
    longint  cur_row[64];
    longint  best;
    longint  c;
    n = pts.size();
    if (n == 0 || k == 0 || k >= n) return '0;
    for (int i = 1; i < n; i++) begin
      v = pts[i];
      j = i;
      while (j > 0 && pts[j-1] > v) begin
        pts[j] = pts[j-1];
        j--;
      end
      pts[j] = v;
    end
    pre[0] = 0;
    for (int i = 0; i < n; i++) pre[i+1] = pre[i] + pts[i];
    for (int lo = 0; lo < n; lo++) begin
      for (int hi = lo; hi < n; hi++) begin
        mid = (lo + hi) / 2;
        cost[lo][hi] = longint'(pts[mid]) * (mid - lo) - (pre[mid] - pre[lo])
                     + (pre[hi+1] - pre[mid+1]) - longint'(pts[mid]) * (hi - mid);
      end
    end
    for (int i = 0; i < n; i++) prev_row[i] = cost[0][i];
    for (int s = 1; s < k; s++) begin
      cur_row[0] = 0;
      for (int jj = 1; jj < n; jj++) begin
        best = 64'h7fffffffffffffff;
        for (int r = 0; r < jj; r++) begin
          c = prev_row[r] + cost[r+1][jj];
          if (c < best) best = c;
        end
        cur_row[jj] = best;
      end
      prev_row = cur_row;
    end
    best = prev_row[n-1];
    return (best > 4194303) ? 22'h3fffff : best[lkm_pkg::DP_W-1:0];
  endfunction

  // Queue one house; on the last house queue the expected distance
  task automatic add_house(input int pos, input bit last);
    house_item_t it;
    it.pos  = pos[15:0];
    it.last = last;
    pending_houses.push_back(it);
    if (loaded_pos.size() < lkm_pkg::MAX_HOUSES)
      loaded_pos.push_back(int'($signed(pos[15:0])));
    if (last) begin
      expected_dist.push_back(least_distance(loaded_pos, office_k));
      loaded_pos.delete();
    end
  endtask

  task automatic add_set(input int n, input int mode);
    int p;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: p = $urandom_range(0, 65535) - 32768;
        1: p = $urandom_range(0, 200) - 100;
        default: p = ($urandom_range(0, 1) ? 32767 : -32768);
      endcase
      add_house(p, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_houses.size() != 0 || expected_dist.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_office_count(input int k);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k[lkm_pkg::K_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    office_k = k;
  endtask

  // Driver: present the next pending house, hold it until the transfer
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      if (pending_houses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= pending_houses[0].pos;
        s_axis_tlast  <= pending_houses[0].last;
        void'(pending_houses.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end else if (!s_axis_tvalid && rst_ni && pending_houses.size() != 0
                 && $urandom_range(0, 99) >= send_idle_pct) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pending_houses[0].pos;
      s_axis_tlast  <= pending_houses[0].last;
      void'(pending_houses.pop_front());
    end
  end

  // Monitor: check each result transfer and stall the receiver at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dist.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", m_axis_tdata));
        end else begin
          if (m_axis_tdata[lkm_pkg::DP_W-1:0] != expected_dist[0]
              || m_axis_tdata[23:lkm_pkg::DP_W] != 0)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      m_axis_tdata, expected_dist[0]));
          void'(expected_dist.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset k of one, single house, extremes, store overflow
    send_idle_pct = 18; recv_idle_pct = 46;
    add_house(5, 1'b1);
    add_set(4, 2);
    add_house(32767, 1'b0); add_house(-32768, 1'b1);
    wait_drained();
    write_office_count(0);
    add_set(5, 0);
    wait_drained();
    write_office_count(3);
    add_set(3, 1);
    add_set(6, 1);
    wait_drained();
    write_office_count(64);
    add_set(66, 0);
    wait_drained();
    write_office_count(127);
    add_set(4, 0);
    wait_drained();
    write_office_count(63);
    add_set(66, 0);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 46; recv_idle_pct = 18; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_office_count((ph % 3 == 0) ? $urandom_range(0, 3) : $urandom_range(1, 8));
      for (int s = 0; s < 17; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        add_set(n, $urandom_range(0, 3) == 0 ? 1 : 0);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
